// ----- sv/zcdp_pkg.sv -----
// Shared types and constants for the zip central directory parser.
// No dependencies; imported by zcdp_core and the top level.
package zcdp_pkg;

    localparam logic [31:0] DIR_SIGNATURE  = 32'h0201_4B50;
    localparam logic [5:0]  HEADER_BYTES   = 6'd46;
    localparam logic [5:0]  LAST_HDR_INDEX = 6'd45;
    localparam logic [15:0] METHOD_STORED  = 16'd0;
    localparam logic [15:0] METHOD_DEFLATE = 16'd8;

    localparam int unsigned ADDR_W = 3;
    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_DIR_BYTES   = 1'b1;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_SKIPPED   = 2'd1,
        ST_BAD_SIG   = 2'd2,
        ST_TRUNCATED = 2'd3
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [31:0] local_header_offset;
        logic [31:0] uncompressed_size;
        logic [31:0] compressed_size;
        logic [15:0] name_length;
        logic        final_result;
    } t_result;

endpackage

// ----- sv/zip_central_directory_parser_top.sv -----
// Top level of the zip central directory parser: APB registers, byte
// channel, two-entry result buffer. Depends on zcdp_pkg and zcdp_core.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_data_byte
//  out     | output    | o_out_valid / i_out_ready | o_status .. o_final_result
//  cfg     | input     | psel, penable, pwrite     | paddr, pwdata, prdata
//
// One byte is taken every cycle while o_in_ready is high; its result, if any, is
// registered in the output register, or in the skid register behind it while the
// output stalls, so o_in_ready stays high until the skid register fills; ready
// drops only while both hold a result. Synchronous active-low reset clears parser
// state, registers and buffer; no clearing pass is needed.
module zip_central_directory_parser_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [31:0]                   o_local_header_offset,
    output logic [31:0]                   o_uncompressed_size,
    output logic [31:0]                   o_compressed_size,
    output logic [15:0]                   o_name_length,
    output logic                          o_final_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [zcdp_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import zcdp_pkg::*;

    logic [15:0] r_entry_count;
    logic [31:0] r_directory_bytes;
    logic        cfg_write;

    logic        accept;
    logic        res_valid;
    t_result     res;

    logic        r_out_valid, r_skid_valid;
    t_result     r_out, r_skid;
    logic        pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_DIR_BYTES) ? r_directory_bytes
                                                   : {16'd0, r_entry_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count     <= '0;
            r_directory_bytes <= '0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_ENTRY_COUNT: r_entry_count     <= pwdata[15:0];
                REG_DIR_BYTES:   r_directory_bytes <= pwdata;
                default:         r_directory_bytes <= r_directory_bytes;
            endcase
        end
    end

    assign o_in_ready = !r_skid_valid;
    assign accept     = i_in_valid && o_in_ready;

    zcdp_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_data_byte       (i_data_byte),
        .i_entry_count     (r_entry_count),
        .i_directory_bytes (r_directory_bytes),
        .o_res_valid       (res_valid),
        .o_res             (res)
    );

    assign pop = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            priority if (r_skid_valid) begin
                if (pop) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (res_valid) begin
                if (!r_out_valid || pop) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end else begin
                r_out_valid <= r_out_valid;
            end
        end
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (!r_out_valid || pop) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_status              = r_out.status;
    assign o_local_header_offset = r_out.local_header_offset;
    assign o_uncompressed_size   = r_out.uncompressed_size;
    assign o_compressed_size     = r_out.compressed_size;
    assign o_name_length         = r_out.name_length;
    assign o_final_result        = r_out.final_result;

endmodule

// ----- sv/zcdp_core.sv -----
// Byte-wise parser state: header capture, skip counting and entry filter.
// Depends on zcdp_pkg; emits at most one result per accepted byte.
module zcdp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic [15:0]       i_entry_count,
    input  logic [31:0]       i_directory_bytes,
    output logic              o_res_valid,
    output zcdp_pkg::t_result o_res
);
    import zcdp_pkg::*;

    logic [31:0] r_pos, n_pos;
    logic [5:0]  r_hidx, n_hidx;
    logic [17:0] r_skip, n_skip;
    logic [15:0] r_done, n_done;
    logic        r_stopped, n_stopped;
    logic [31:0] r_sig, n_sig;
    logic [15:0] r_method, n_method;
    logic [63:0] r_sizes, n_sizes;
    logic [47:0] r_lengths, n_lengths;
    logic [31:0] r_offset, n_offset;

    logic [5:0]  sizes_lane, lengths_lane, offset_lane;
    logic [31:0] csize, usize;
    logic [15:0] nlen;
    logic [17:0] skip;
    logic        pass;
    logic        name_over;
    logic        next_over;
    logic        hdr_over;

    always_comb begin
        sizes_lane   = r_hidx - 6'd20;
        lengths_lane = r_hidx - 6'd28;
        offset_lane  = r_hidx - 6'd42;
        hdr_over     = ({1'b0, r_pos} + 33'(HEADER_BYTES)) > {1'b0, i_directory_bytes};

        n_pos     = r_pos;
        n_hidx    = r_hidx;
        n_skip    = r_skip;
        n_done    = r_done;
        n_stopped = r_stopped;
        n_sig     = r_sig;
        n_method  = r_method;
        n_sizes   = r_sizes;
        n_lengths = r_lengths;
        n_offset  = r_offset;

        if (r_hidx < 6'd4) begin
            n_sig[8*r_hidx[1:0] +: 8] = i_data_byte;
        end else if (r_hidx == 6'd10 || r_hidx == 6'd11) begin
            n_method[8*r_hidx[0] +: 8] = i_data_byte;
        end else if (r_hidx >= 6'd20 && r_hidx < 6'd28) begin
            n_sizes[8*sizes_lane[2:0] +: 8] = i_data_byte;
        end else if (r_hidx >= 6'd28 && r_hidx < 6'd34) begin
            n_lengths[8*lengths_lane[2:0] +: 8] = i_data_byte;
        end else if (r_hidx >= 6'd42) begin
            n_offset[8*offset_lane[1:0] +: 8] = i_data_byte;
        end

        csize = n_sizes[31:0];
        usize = n_sizes[63:32];
        nlen  = n_lengths[15:0];
        skip  = 18'(nlen) + 18'(n_lengths[31:16]) + 18'(n_lengths[47:32]);
        pass  = (nlen != 16'd0) && (usize != 32'd0) &&
                (n_method == METHOD_STORED ||
                 (n_method == METHOD_DEFLATE && csize != 32'd0));
        n_pos = r_pos + 32'd1;
        name_over = ({1'b0, n_pos} + {17'd0, nlen}) > {1'b0, i_directory_bytes};
        next_over = ({2'b0, n_pos} + {16'd0, skip} + 34'(HEADER_BYTES))
                    > {2'b0, i_directory_bytes};
        n_pos = r_pos;

        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_accept && !r_stopped) begin
            priority if (r_skip != 18'd0) begin
                n_sig     = r_sig;
                n_method  = r_method;
                n_sizes   = r_sizes;
                n_lengths = r_lengths;
                n_offset  = r_offset;
                n_skip    = r_skip - 18'd1;
                n_pos     = r_pos + 32'd1;
            end else if (r_hidx == 6'd0 && r_done >= i_entry_count) begin
                n_sig     = r_sig;
                n_stopped = 1'b1;
            end else if (r_hidx == 6'd0 && hdr_over) begin
                n_sig              = r_sig;
                n_stopped          = 1'b1;
                o_res_valid        = 1'b1;
                o_res.status       = ST_TRUNCATED;
                o_res.final_result = 1'b1;
            end else begin
                n_pos = r_pos + 32'd1;
                if (r_hidx < LAST_HDR_INDEX) begin
                    n_hidx = r_hidx + 6'd1;
                end else begin
                    n_hidx      = 6'd0;
                    n_done      = r_done + 16'd1;
                    o_res_valid = 1'b1;
                    if (n_sig != DIR_SIGNATURE) begin
                        n_stopped          = 1'b1;
                        o_res.status       = ST_BAD_SIG;
                        o_res.final_result = 1'b1;
                    end else begin
                        if (pass && name_over) begin
                            o_res.status = ST_TRUNCATED;
                            n_stopped    = 1'b1;
                        end else begin
                            o_res.status = pass ? ST_ACCEPTED : ST_SKIPPED;
                            n_skip       = skip;
                            if (n_done >= i_entry_count || next_over) begin
                                n_stopped = 1'b1;
                            end
                        end
                        o_res.local_header_offset = n_offset;
                        o_res.uncompressed_size   = usize;
                        o_res.compressed_size     =
                            (n_method == METHOD_STORED) ? 32'd0 : csize;
                        o_res.name_length         = nlen;
                        o_res.final_result        = n_stopped;
                    end
                end
            end
        end else begin
            n_sig     = r_sig;
            n_method  = r_method;
            n_sizes   = r_sizes;
            n_lengths = r_lengths;
            n_offset  = r_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_hidx    <= '0;
            r_skip    <= '0;
            r_done    <= '0;
            r_stopped <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_hidx    <= n_hidx;
            r_skip    <= n_skip;
            r_done    <= n_done;
            r_stopped <= n_stopped;
        end
        r_sig     <= n_sig;
        r_method  <= n_method;
        r_sizes   <= n_sizes;
        r_lengths <= n_lengths;
        r_offset  <= n_offset;
    end

endmodule
